// ===== design/self_organizing_list_lookup_top_macros.svh =====
// Assertion macros for the self-organizing list lookup block.
// Used by the top level; the macros expect clk_i and rst_ni in scope.
`ifndef SELF_ORGANIZING_LIST_LOOKUP_TOP_MACROS_SVH
`define SELF_ORGANIZING_LIST_LOOKUP_TOP_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define SOL_ASSERT_NOW(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("sol assertion failed");

// Next-cycle implication, checked outside reset.
`define SOL_ASSERT_NEXT(label, ante, cons) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("sol assertion failed");

`endif

// ===== design/sol_pkg.sv =====
// Shared constants, codes and link types of the self-organizing list lookup.
// Used by every module of the block; depends on nothing.
`default_nettype none

package sol_pkg;

  localparam int LIST_DEPTH  = 64;
  localparam int COUNT_BITS  = 16;
  localparam int KEY_W       = 32;
  localparam int IDX_W       = $clog2(LIST_DEPTH);
  localparam int ENTRY_IDX_W = 6;
  localparam int POS_W       = 6;
  localparam int LEN_W       = 7;
  localparam int POL_W       = 2;
  localparam int CFG_IDX_W   = 1;
  localparam int CFG_DATA_W  = 7;
  localparam int IN_TDATA_W  = ((ENTRY_IDX_W + KEY_W + 7) / 8) * 8;
  localparam int OUT_TDATA_W = ((POS_W + 7) / 8) * 8;

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};

  typedef enum logic [POL_W-1:0] {
    POL_FRONT     = 2'd0,
    POL_TRANSPOSE = 2'd1,
    POL_FREQ      = 2'd2,
    POL_HOLD      = 2'd3
  } policy_e;

  typedef enum logic [0:0] {
    REQ_WRITE  = 1'b0,
    REQ_LOOKUP = 1'b1
  } req_e;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_POLICY = 1'b0,
    CFG_LENGTH = 1'b1
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_CMP,
    ST_UPD
  } state_e;

  typedef struct packed {
    logic in_ready;
    logic cmp_en;
    logic upd_en;
  } seq_t;

  typedef struct packed {
    logic                 cmp_en;
    logic                 upd_en;
    logic                 is_lookup;
    policy_e              policy;
    logic [KEY_W-1:0]     key;
    logic [KEY_W-1:0]     front_key;
    logic                 front_take;
  } cell_ctrl_t;

  typedef struct packed {
    logic                  pred;
    logic                  seen;
    logic [KEY_W-1:0]      key;
    logic [COUNT_BITS-1:0] count;
  } down_t;

  typedef struct packed {
    logic                  hit;
    logic                  swap_up;
    logic [COUNT_BITS-1:0] cnt_inc;
  } up_t;

endpackage

`default_nettype wire

// ===== design/sol_cell.sv =====
// One list entry: key, access count, match flag and the reorder logic.
// Depends on sol_pkg; exchanges data with both neighbors every cycle.
`default_nettype none

module sol_cell (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  sol_pkg::cell_ctrl_t ctrl_i,
  input  logic               active_i,
  input  logic               wr_sel_i,
  input  sol_pkg::down_t     down_i,
  input  sol_pkg::up_t       up_i,
  output sol_pkg::down_t     down_o,
  output sol_pkg::up_t       up_o
);

  logic [sol_pkg::KEY_W-1:0]      key_q, key_d;
  logic [sol_pkg::COUNT_BITS-1:0] count_q, count_d;
  logic [sol_pkg::COUNT_BITS-1:0] cnt_inc;
  logic                           match_q;
  logic                           hit;
  logic                           swap_up;

  assign hit     = match_q && !down_i.seen;
  assign cnt_inc = (count_q == sol_pkg::COUNT_MAX) ? count_q : count_q + 1'b1;
  assign swap_up = hit && down_i.pred && (ctrl_i.policy == sol_pkg::POL_FREQ) &&
                   (down_i.count < cnt_inc);

  always_comb begin
    key_d   = key_q;
    count_d = count_q;
    if (ctrl_i.upd_en) begin
      if (!ctrl_i.is_lookup) begin
        if (wr_sel_i) begin
          key_d   = ctrl_i.key;
          count_d = '0;
        end
      end else begin
        case (ctrl_i.policy)
          sol_pkg::POL_FRONT: begin
            if (hit && down_i.pred) begin
              key_d = ctrl_i.front_key;
            end else if (!down_i.pred && ctrl_i.front_take) begin
              key_d = ctrl_i.key;
            end
          end
          sol_pkg::POL_TRANSPOSE: begin
            if (hit && down_i.pred) begin
              key_d = down_i.key;
            end else if (up_i.hit) begin
              key_d = ctrl_i.key;
            end
          end
          sol_pkg::POL_FREQ: begin
            if (swap_up) begin
              key_d   = down_i.key;
              count_d = down_i.count;
            end else if (hit) begin
              count_d = cnt_inc;
            end else if (up_i.swap_up) begin
              key_d   = ctrl_i.key;
              count_d = up_i.cnt_inc;
            end
          end
          default: begin
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk_i) begin
    key_q <= key_d;
    if (ctrl_i.cmp_en) begin
      match_q <= active_i && (key_q == ctrl_i.key);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else begin
      count_q <= count_d;
    end
  end

  assign down_o.pred  = 1'b1;
  assign down_o.seen  = down_i.seen || match_q;
  assign down_o.key   = key_q;
  assign down_o.count = count_q;

  assign up_o.hit     = hit;
  assign up_o.swap_up = swap_up;
  assign up_o.cnt_inc = cnt_inc;

endmodule

`default_nettype wire

// ===== design/sol_seq.sv =====
// Request sequencer: accept, compare and update phases of one item.
// Depends on sol_pkg.
`default_nettype none

module sol_seq (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          out_space_i,
  output sol_pkg::seq_t seq_o
);

  sol_pkg::state_e state_q, state_d;

  always_comb begin
    state_d = state_q;
    case (state_q)
      sol_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          state_d = sol_pkg::ST_CMP;
        end
      end
      sol_pkg::ST_CMP: begin
        if (out_space_i) begin
          state_d = sol_pkg::ST_UPD;
        end
      end
      sol_pkg::ST_UPD: begin
        state_d = in_valid_i ? sol_pkg::ST_CMP : sol_pkg::ST_IDLE;
      end
      default: begin
        state_d = sol_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    seq_o.in_ready = (state_q == sol_pkg::ST_IDLE) || (state_q == sol_pkg::ST_UPD);
    seq_o.cmp_en   = (state_q == sol_pkg::ST_CMP);
    seq_o.upd_en   = (state_q == sol_pkg::ST_UPD);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= sol_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

endmodule

`default_nettype wire

// ===== design/self_organizing_list_lookup_top.sv =====
// Self-organizing list lookup: top level with the chain of list cells.
// Depends on sol_pkg, sol_cell, sol_seq and the assertion macro header.
//
// Use: items enter on the s_axis channel. A write item stores a key at an
// entry index and clears that entry's access count; a lookup item searches
// the first list_length entries from position zero for the key. Every item
// gives exactly one result item on the m_axis channel with a found flag and
// the hit position before reordering. After a hit the list reorders by the
// policy register: swap to front, transpose, frequency-count transpose or hold.
// Configuration writes arrive on the cfg channel, which is always ready.
// An accepted item passes to the compare state and then to the update state,
// where its result is registered; the compare state waits while a held
// result has not been taken. A new item can be accepted in the update state
// of the previous one, but not during its compare.
// When the receiver stalls, the held result blocks the next compare from
// finishing, and no further item is accepted meanwhile.
// Reset clears the sequencer, the output valid and the counts, and sets the
// policy to swap to front and the length to 64; keys stay undefined until written.
`default_nettype none
`include "self_organizing_list_lookup_top_macros.svh"

module self_organizing_list_lookup_top (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               s_axis_tvalid,
  output logic                               s_axis_tready,
  // entry_index [5:0], key [37:6], zero padding above.
  input  logic [sol_pkg::IN_TDATA_W-1:0]     s_axis_tdata,
  // req_type [0].
  input  logic [0:0]                         s_axis_tuser,
  output logic                               m_axis_tvalid,
  input  logic                               m_axis_tready,
  // position [5:0], zero padding above.
  output logic [sol_pkg::OUT_TDATA_W-1:0]    m_axis_tdata,
  // found [0].
  output logic [0:0]                         m_axis_tuser,
  input  logic                               cfg_valid_i,
  output logic                               cfg_ready_o,
  input  logic [sol_pkg::CFG_IDX_W-1:0]      cfg_index_i,
  input  logic [sol_pkg::CFG_DATA_W-1:0]     cfg_data_i
);

  localparam int N = sol_pkg::LIST_DEPTH;

  sol_pkg::seq_t                     seq;
  sol_pkg::cell_ctrl_t               cell_ctrl;
  sol_pkg::down_t                    down [N+1];
  sol_pkg::up_t                      up   [N+1];
  logic [N-1:0]                      active;
  logic [N-1:0]                      wr_sel;
  logic [N-1:0]                      hit_vec;

  sol_pkg::policy_e                  policy_q;
  logic [sol_pkg::LEN_W-1:0]         length_q;
  sol_pkg::req_e                     req_q;
  logic [sol_pkg::ENTRY_IDX_W-1:0]   idx_q;
  logic [sol_pkg::KEY_W-1:0]         key_q;

  logic                              out_valid_q, out_valid_d;
  logic                              found_q, found_d;
  logic [sol_pkg::POS_W-1:0]         pos_q, pos_d;
  logic [sol_pkg::IDX_W-1:0]         pos_full;
  logic                              any_hit;
  logic                              in_fire;

  assign in_fire       = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = seq.in_ready;
  assign cfg_ready_o   = 1'b1;

  sol_seq u_seq (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .out_space_i (!out_valid_q || m_axis_tready),
    .seq_o       (seq)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      policy_q <= sol_pkg::POL_FRONT;
      length_q <= sol_pkg::LEN_W'(64);
    end else if (cfg_valid_i) begin
      case (sol_pkg::cfg_idx_e'(cfg_index_i))
        sol_pkg::CFG_POLICY: policy_q <= sol_pkg::policy_e'(cfg_data_i[sol_pkg::POL_W-1:0]);
        sol_pkg::CFG_LENGTH: length_q <= cfg_data_i[sol_pkg::LEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      req_q <= sol_pkg::req_e'(s_axis_tuser[0]);
      idx_q <= s_axis_tdata[sol_pkg::ENTRY_IDX_W-1:0];
      key_q <= s_axis_tdata[sol_pkg::ENTRY_IDX_W +: sol_pkg::KEY_W];
    end
  end

  assign cell_ctrl.cmp_en     = seq.cmp_en;
  assign cell_ctrl.upd_en     = seq.upd_en;
  assign cell_ctrl.is_lookup  = (req_q == sol_pkg::REQ_LOOKUP);
  assign cell_ctrl.policy     = policy_q;
  assign cell_ctrl.key        = key_q;
  assign cell_ctrl.front_key  = down[1].key;
  assign cell_ctrl.front_take = any_hit && !up[0].hit;

  assign down[0].pred  = 1'b0;
  assign down[0].seen  = 1'b0;
  assign down[0].key   = '0;
  assign down[0].count = '0;

  assign up[N].hit     = 1'b0;
  assign up[N].swap_up = 1'b0;
  assign up[N].cnt_inc = '0;

  for (genvar i = 0; i < N; i++) begin : g_cell
    assign active[i]  = 32'(i) < 32'(length_q);
    assign wr_sel[i]  = 32'(i) == 32'(idx_q);
    assign hit_vec[i] = up[i].hit;

    sol_cell u_cell (
      .clk_i    (clk_i),
      .rst_ni   (rst_ni),
      .ctrl_i   (cell_ctrl),
      .active_i (active[i]),
      .wr_sel_i (wr_sel[i]),
      .down_i   (down[i]),
      .up_i     (up[i+1]),
      .down_o   (down[i+1]),
      .up_o     (up[i])
    );
  end

  assign any_hit = down[N].seen;

  always_comb begin
    pos_full = '0;
    for (int i = 0; i < N; i++) begin
      pos_full = pos_full | (hit_vec[i] ? sol_pkg::IDX_W'(i) : '0);
    end
  end

  always_comb begin
    found_d     = cell_ctrl.is_lookup && any_hit;
    pos_d       = found_d ? sol_pkg::POS_W'(pos_full) : '0;
    out_valid_d = out_valid_q;
    if (seq.upd_en) begin
      out_valid_d = 1'b1;
    end else if (m_axis_tready) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else begin
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (seq.upd_en) begin
      found_q <= found_d;
      pos_q   <= pos_d;
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {{(sol_pkg::OUT_TDATA_W - sol_pkg::POS_W){1'b0}}, pos_q};
  assign m_axis_tuser  = found_q;

  `SOL_ASSERT_NOW(a_single_hit, seq.upd_en && cell_ctrl.is_lookup, $onehot0(hit_vec))
  `SOL_ASSERT_NOW(a_out_free_on_update, seq.upd_en, !out_valid_q)
  `SOL_ASSERT_NEXT(a_accept_starts_compare, in_fire, seq.cmp_en)
  `SOL_ASSERT_NOW(a_miss_pos_zero, out_valid_q && !found_q, pos_q == '0)

endmodule

`default_nettype wire

// ===== dv/self_organizing_list_lookup_top_test.sv =====
// Self-checking testbench for the self-organizing list lookup top level.
// Drives the item stream and the cfg channel and predicts each result item.
// Depends on sol_pkg and self_organizing_list_lookup_top.
`timescale 1ns / 1ps

module self_organizing_list_lookup_top_test;

  localparam int CYCLE_LIMIT = 200_000;
  localparam int LONG_HOLD = 300;
  localparam int PHASES = 8;
  localparam int PHASE_ITEMS = 45;
  localparam logic [sol_pkg::KEY_W-1:0] KEY_MIN = 32'h8000_0000;
  localparam logic [sol_pkg::KEY_W-1:0] KEY_MAX = 32'h7FFF_FFFF;
  localparam logic [sol_pkg::KEY_W-1:0] KEY_ONES = 32'hFFFF_FFFF;
  localparam logic [sol_pkg::KEY_W-1:0] KEY_MARK = 32'h5555_AAAA;

  typedef struct packed {
    logic                      found;
    logic [sol_pkg::POS_W-1:0] position;
  } lookup_outcome_t;

  typedef struct {
    bit                        is_cfg;
    sol_pkg::policy_e          policy;
    logic [sol_pkg::LEN_W-1:0] length;
    sol_pkg::req_e             req;
    logic [5:0]                idx;
    logic [sol_pkg::KEY_W-1:0] key;
    bit                        known;
    lookup_outcome_t           outcome;
  } step_row_t;

  logic                                clk_i = 1'b0;
  logic                                rst_ni = 1'b0;
  logic                                s_axis_tvalid = 1'b0;
  logic                                s_axis_tready;
  logic [sol_pkg::IN_TDATA_W-1:0]      s_axis_tdata = '0;
  logic [0:0]                          s_axis_tuser = '0;
  logic                                m_axis_tvalid;
  logic                                m_axis_tready = 1'b0;
  logic [sol_pkg::OUT_TDATA_W-1:0]     m_axis_tdata;
  logic [0:0]                          m_axis_tuser;
  logic                                cfg_valid_i = 1'b0;
  logic                                cfg_ready_o;
  logic [sol_pkg::CFG_IDX_W-1:0]       cfg_index_i = '0;
  logic [sol_pkg::CFG_DATA_W-1:0]      cfg_data_i = '0;

  logic [sol_pkg::KEY_W-1:0]      stored_keys [sol_pkg::LIST_DEPTH];
  logic [sol_pkg::COUNT_BITS-1:0] hit_counts [sol_pkg::LIST_DEPTH];
  sol_pkg::policy_e               active_policy = sol_pkg::POL_FRONT;
  logic [sol_pkg::LEN_W-1:0]      active_length = 7'd64;
  lookup_outcome_t                pending_outcomes [$];
  step_row_t                      directed_rows [$];

  bit idle_on = 1'b1;
  bit hold_go = 1'b0;
  bit hold_active = 1'b0;
  int fail_count = 0;
  int cycle_count = 0;

  sol_pkg::policy_e phase_policy [PHASES] = '{
    sol_pkg::POL_FRONT, sol_pkg::POL_TRANSPOSE, sol_pkg::POL_FREQ, sol_pkg::POL_HOLD,
    sol_pkg::POL_FREQ, sol_pkg::POL_FRONT, sol_pkg::POL_TRANSPOSE, sol_pkg::POL_FREQ};
  logic [sol_pkg::LEN_W-1:0] phase_length [PHASES] = '{7'd64, 7'd37, 7'd64, 7'd100,
                                                       7'd2, 7'd127, 7'd1, 7'd48};

  self_organizing_list_lookup_top dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_ready_o  (cfg_ready_o),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  function automatic lookup_outcome_t apply_request(sol_pkg::req_e req, logic [5:0] idx,
                                                    logic [sol_pkg::KEY_W-1:0] key);
    lookup_outcome_t                res;
    int                             span;
    int                             hit_at;
    logic [sol_pkg::KEY_W-1:0]      k;
    logic [sol_pkg::COUNT_BITS-1:0] c;
    res = '0;
    if (req == sol_pkg::REQ_WRITE) begin
      stored_keys[idx] = key;
      hit_counts[idx] = '0;
      return res;
    end
    span = (active_length > sol_pkg::LIST_DEPTH) ? sol_pkg::LIST_DEPTH : int'(active_length);
    hit_at = -1;
    for (int i = 0; i < span; i++) begin
      if (hit_at < 0 && stored_keys[i] == key) hit_at = i;
    end
    if (hit_at < 0) return res;
    res.found = 1'b1;
    res.position = hit_at[sol_pkg::POS_W-1:0];
    case (active_policy)
      sol_pkg::POL_FRONT: begin
        if (hit_at != 0) begin
          k = stored_keys[0];
          stored_keys[0] = stored_keys[hit_at];
          stored_keys[hit_at] = k;
        end
      end
      sol_pkg::POL_TRANSPOSE: begin
        if (hit_at != 0) begin
          k = stored_keys[hit_at-1];
          stored_keys[hit_at-1] = stored_keys[hit_at];
          stored_keys[hit_at] = k;
        end
      end
      sol_pkg::POL_FREQ: begin
        if (hit_counts[hit_at] != sol_pkg::COUNT_MAX) begin
          hit_counts[hit_at] = hit_counts[hit_at] + 1'b1;
        end
        if (hit_at != 0 && hit_counts[hit_at-1] < hit_counts[hit_at]) begin
          k = stored_keys[hit_at-1];
          c = hit_counts[hit_at-1];
          stored_keys[hit_at-1] = stored_keys[hit_at];
          hit_counts[hit_at-1] = hit_counts[hit_at];
          stored_keys[hit_at] = k;
          hit_counts[hit_at] = c;
        end
      end
      default: ;
    endcase
    return res;
  endfunction

  function automatic step_row_t item_row(sol_pkg::req_e req, logic [5:0] idx,
                                         logic [sol_pkg::KEY_W-1:0] key);
    step_row_t row;
    row = '{policy: sol_pkg::POL_FRONT, req: sol_pkg::REQ_WRITE, default: '0};
    row.req = req;
    row.idx = idx;
    row.key = key;
    return row;
  endfunction

  function automatic step_row_t known_row(sol_pkg::req_e req, logic [5:0] idx,
                                          logic [sol_pkg::KEY_W-1:0] key,
                                          logic found, logic [sol_pkg::POS_W-1:0] position);
    step_row_t row;
    row = item_row(req, idx, key);
    row.known = 1'b1;
    row.outcome = '{found: found, position: position};
    return row;
  endfunction

  function automatic step_row_t config_row(sol_pkg::policy_e policy,
                                           logic [sol_pkg::LEN_W-1:0] length);
    step_row_t row;
    row = '{policy: sol_pkg::POL_FRONT, req: sol_pkg::REQ_WRITE, default: '0};
    row.is_cfg = 1'b1;
    row.policy = policy;
    row.length = length;
    return row;
  endfunction

  task automatic send_item(sol_pkg::req_e req, logic [5:0] idx,
                           logic [sol_pkg::KEY_W-1:0] key,
                           bit known = 1'b0, lookup_outcome_t outcome = '0);
    int              gap;
    lookup_outcome_t predicted;
    gap = idle_on ? $urandom_range(0, 13) : 0;
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= sol_pkg::IN_TDATA_W'({key, idx});
    s_axis_tuser <= req;
    do @(posedge clk_i); while (!s_axis_tready);
    predicted = apply_request(req, idx, key);
    pending_outcomes.push_back(known ? outcome : predicted);
  endtask

  task automatic drain(int settle);
    s_axis_tvalid <= 1'b0;
    while (pending_outcomes.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  task automatic set_config(sol_pkg::policy_e policy, logic [sol_pkg::LEN_W-1:0] length);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= sol_pkg::CFG_POLICY;
    cfg_data_i <= sol_pkg::CFG_DATA_W'(policy);
    do @(posedge clk_i); while (!cfg_ready_o);
    active_policy = policy;
    cfg_index_i <= sol_pkg::CFG_LENGTH;
    cfg_data_i <= length;
    do @(posedge clk_i); while (!cfg_ready_o);
    active_length = length;
    cfg_valid_i <= 1'b0;
  endtask

  initial begin
    lookup_outcome_t got;
    lookup_outcome_t want;
    int              stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      stall = idle_on ? $urandom_range(0, 13) : 0;
      if (stall > 0 || hold_active) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
        while (hold_active) @(posedge clk_i);
      end
      m_axis_tready <= 1'b1;
      do @(posedge clk_i); while (!m_axis_tvalid);
      got.found = m_axis_tuser[0];
      got.position = m_axis_tdata[sol_pkg::POS_W-1:0];
      if (pending_outcomes.size() == 0) begin
        $error("result item with nothing expected: found %0d position %0d",
               got.found, got.position);
        fail_count++;
      end else begin
        want = pending_outcomes.pop_front();
        if (got.found !== want.found) begin
          $error("found: expected %0d, actual %0d", want.found, got.found);
          fail_count++;
        end
        if (got.position !== want.position) begin
          $error("position: expected %0d, actual %0d", want.position, got.position);
          fail_count++;
        end
      end
    end
  end

  initial begin
    wait (hold_go);
    hold_active <= 1'b1;
    repeat (LONG_HOLD) @(posedge clk_i);
    hold_active <= 1'b0;
  end

  initial begin
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk_i);
      cycle_count++;
    end
    $display("[FAIL] regression broken");
    $finish;
  end

  initial begin
    int                        roll;
    int                        span;
    logic [5:0]                idx;
    logic [sol_pkg::KEY_W-1:0] key;
    foreach (hit_counts[i]) begin
      hit_counts[i] = '0;
      stored_keys[i] = '0;
    end
    repeat (12) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Every entry is written before the first lookup.
    for (int i = 0; i < sol_pkg::LIST_DEPTH; i++) begin
      case (i)
        0: key = KEY_MIN;
        1: key = KEY_MAX;
        2: key = '0;
        3: key = KEY_ONES;
        default: key = 32'h1357_9BDF * i;
      endcase
      send_item(sol_pkg::REQ_WRITE, i[5:0], key);
    end

    directed_rows.push_back(known_row(sol_pkg::REQ_LOOKUP, 6'd0, KEY_MIN, 1'b1, 6'd0));
    directed_rows.push_back(known_row(sol_pkg::REQ_LOOKUP, 6'd17, KEY_MAX, 1'b1, 6'd1));
    directed_rows.push_back(item_row(sol_pkg::REQ_LOOKUP, 6'd63, KEY_MIN));
    directed_rows.push_back(item_row(sol_pkg::REQ_LOOKUP, 6'd0, 32'h0000_0001));
    directed_rows.push_back(known_row(sol_pkg::REQ_WRITE, 6'd63, KEY_MARK, 1'b0, 6'd0));
    directed_rows.push_back(item_row(sol_pkg::REQ_LOOKUP, 6'd0, KEY_MARK));
    directed_rows.push_back(config_row(sol_pkg::POL_TRANSPOSE, 7'd64));
    directed_rows.push_back(item_row(sol_pkg::REQ_LOOKUP, 6'd0, KEY_ONES));
    directed_rows.push_back(item_row(sol_pkg::REQ_LOOKUP, 6'd0, KEY_ONES));
    directed_rows.push_back(config_row(sol_pkg::POL_FREQ, 7'd64));
    directed_rows.push_back(item_row(sol_pkg::REQ_LOOKUP, 6'd0, KEY_MARK));
    directed_rows.push_back(item_row(sol_pkg::REQ_LOOKUP, 6'd0, KEY_ONES));
    directed_rows.push_back(item_row(sol_pkg::REQ_LOOKUP, 6'd0, KEY_ONES));
    directed_rows.push_back(item_row(sol_pkg::REQ_LOOKUP, 6'd0, KEY_ONES));
    directed_rows.push_back(config_row(sol_pkg::POL_HOLD, 7'd0));
    directed_rows.push_back(known_row(sol_pkg::REQ_LOOKUP, 6'd0, KEY_ONES, 1'b0, 6'd0));
    directed_rows.push_back(config_row(sol_pkg::POL_HOLD, 7'd127));
    directed_rows.push_back(item_row(sol_pkg::REQ_LOOKUP, 6'd0, KEY_MIN));
    directed_rows.push_back(item_row(sol_pkg::REQ_LOOKUP, 6'd0, KEY_MIN));
    directed_rows.push_back(config_row(sol_pkg::POL_FRONT, 7'd1));
    directed_rows.push_back(item_row(sol_pkg::REQ_LOOKUP, 6'd0, KEY_MAX));
    directed_rows.push_back(item_row(sol_pkg::REQ_LOOKUP, 6'd0, KEY_ONES));
    directed_rows.push_back(known_row(sol_pkg::REQ_WRITE, 6'd0, '0, 1'b0, 6'd0));
    directed_rows.push_back(config_row(sol_pkg::POL_TRANSPOSE, 7'd64));
    directed_rows.push_back(item_row(sol_pkg::REQ_LOOKUP, 6'd5, '0));

    foreach (directed_rows[r]) begin
      if (directed_rows[r].is_cfg) begin
        drain(4);
        set_config(directed_rows[r].policy, directed_rows[r].length);
      end else begin
        send_item(directed_rows[r].req, directed_rows[r].idx, directed_rows[r].key,
                  directed_rows[r].known, directed_rows[r].outcome);
      end
    end

    // Back-to-back hits on the two front entries raise their counts.
    drain(4);
    set_config(sol_pkg::POL_FREQ, 7'd64);
    idle_on = 1'b0;
    repeat (6) send_item(sol_pkg::REQ_LOOKUP, 6'd0, stored_keys[0]);
    repeat (2) send_item(sol_pkg::REQ_LOOKUP, 6'd0, stored_keys[1]);

    for (int ph = 0; ph < PHASES; ph++) begin
      drain(4);
      set_config(phase_policy[ph], phase_length[ph]);
      idle_on = (ph != 5);
      if (ph == 2) hold_go = 1'b1;
      span = (active_length > sol_pkg::LIST_DEPTH) ? sol_pkg::LIST_DEPTH
                                                   : int'(active_length);
      if (span == 0) span = sol_pkg::LIST_DEPTH;
      repeat (PHASE_ITEMS) begin
        roll = $urandom_range(0, 99);
        idx = $urandom_range(0, 63);
        if (roll < 25) begin
          key = ($urandom_range(0, 3) == 0) ? stored_keys[$urandom_range(0, 63)] : $urandom;
          send_item(sol_pkg::REQ_WRITE, idx, key);
        end else if (roll < 85) begin
          send_item(sol_pkg::REQ_LOOKUP, idx, stored_keys[$urandom_range(0, span - 1)]);
        end else begin
          send_item(sol_pkg::REQ_LOOKUP, idx, $urandom);
        end
      end
    end

    drain(8);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

// ===== files.f =====
+incdir+design
design/sol_pkg.sv
design/sol_cell.sv
design/sol_seq.sv
design/self_organizing_list_lookup_top.sv
dv/self_organizing_list_lookup_top_test.sv
